// File: design/qvr_pkg.sv
// Shared constants and types for the quaternion vector rotation block.
// No dependencies; imported by quaternion_vector_rotate_top and tb_top.
`timescale 1ns / 1ps

package qvr_pkg;

  localparam int QUAT_WIDTH    = 16;
  localparam int CFG_IDX_WIDTH = 2;
  localparam int FRAC_SHIFT    = 28;

  localparam logic signed [QUAT_WIDTH-1:0] QUAT_W_RESET = 16'sd16384;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_QUAT_X = 2'd0,
    REG_QUAT_Y = 2'd1,
    REG_QUAT_Z = 2'd2,
    REG_QUAT_W = 2'd3
  } cfg_reg_t;

endpackage

// File: design/quaternion_vector_rotate_top.sv
// Quaternion sandwich rotation of a vector stream: r = q * v * conj(q).
// Depends on qvr_pkg for the quaternion width, register codes and rounding shift.
`timescale 1ns / 1ps

// Usage
//   Configuration: write quat_x, quat_y, quat_z, quat_w (indexes 0..3, Q2.14)
//   on cfg_valid/cfg_ready while no vector is in flight. cfg_ready is always high.
//   Input: one vector (in_x, in_y, in_z) per transaction, taken when in_valid is
//   high and in_stall is low.
//   Output: out_x, out_y, out_z and saturated, one transaction per input, handed
//   over when out_valid is high and out_stall is low.
//   Pipeline: five register stages (q*v products, t sums, t*conj(q) products,
//   rounded sums, saturation and output register). Throughput: one vector per
//   cycle while out_stall is low, with each stage loading every cycle.
//   Stall: each stage holds while it is full and the one after it cannot take
//   its data; empty stages keep filling, and in_stall rises only when the first
//   stage is full and blocked. Nothing is dropped or repeated.
//   Reset: all stages empty, q = (0, 0, 0, 1.0), the identity rotation.
//   The result is scaled by |q|^2; q is not normalised.
module quaternion_vector_rotate_top #(
  parameter int VEC_WIDTH = 18
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [qvr_pkg::CFG_IDX_WIDTH-1:0]     cfg_index,
  input  logic [qvr_pkg::QUAT_WIDTH-1:0]        cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [VEC_WIDTH-1:0]           in_x,
  input  logic signed [VEC_WIDTH-1:0]           in_y,
  input  logic signed [VEC_WIDTH-1:0]           in_z,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [VEC_WIDTH-1:0]           out_x,
  output logic signed [VEC_WIDTH-1:0]           out_y,
  output logic signed [VEC_WIDTH-1:0]           out_z,
  output logic                                  saturated
);
  import qvr_pkg::*;

  localparam int PW  = VEC_WIDTH + QUAT_WIDTH;
  localparam int TW  = PW + 2;
  localparam int RW  = TW + QUAT_WIDTH;
  localparam int SW  = RW + 2;
  localparam int RNW = SW - FRAC_SHIFT;

  localparam logic signed [SW-1:0] ROUND_BIAS = SW'(64'd1 << (FRAC_SHIFT - 1));
  localparam logic signed [VEC_WIDTH-1:0] VEC_MAX = {1'b0, {(VEC_WIDTH-1){1'b1}}};
  localparam logic signed [VEC_WIDTH-1:0] VEC_MIN = {1'b1, {(VEC_WIDTH-1){1'b0}}};

  logic signed [QUAT_WIDTH-1:0] qx, qy, qz, qw;

  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4, en_o;

  logic signed [PW-1:0] p_wx, p_yz, p_zy, p_wy, p_xz, p_zx;
  logic signed [PW-1:0] p_wz, p_xy, p_yx, p_xx, p_yy, p_zz;

  logic signed [TW-1:0] tx, ty, tz, tw;

  logic signed [RW-1:0] m_wx, m_xw, m_yz, m_zy;
  logic signed [RW-1:0] m_wy, m_xz, m_yw, m_zx;
  logic signed [RW-1:0] m_wz, m_xy, m_yx, m_zw;

  logic signed [SW-1:0] sum_x, sum_y, sum_z;
  logic signed [RNW-1:0] rnd_x, rnd_y, rnd_z;

  logic fit_x, fit_y, fit_z;
  logic signed [VEC_WIDTH-1:0] out_x_next, out_y_next, out_z_next;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      qx <= '0;
      qy <= '0;
      qz <= '0;
      qw <= QUAT_W_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_QUAT_X: qx <= cfg_data;
        REG_QUAT_Y: qy <= cfg_data;
        REG_QUAT_Z: qz <= cfg_data;
        REG_QUAT_W: qw <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage enables: a stage loads when empty or when the next stage loads
  assign en_o     = !out_valid || !out_stall;
  assign en4      = !v4 || en_o;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_stall = !en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1)  v1        <= in_valid;
      if (en2)  v2        <= v1;
      if (en3)  v3        <= v2;
      if (en4)  v4        <= v3;
      if (en_o) out_valid <= v4;
    end
  end

  // stage 1: q * v products
  always_ff @(posedge clk) begin
    if (en1) begin
      p_wx <= PW'(qw) * PW'(in_x);
      p_yz <= PW'(qy) * PW'(in_z);
      p_zy <= PW'(qz) * PW'(in_y);
      p_wy <= PW'(qw) * PW'(in_y);
      p_xz <= PW'(qx) * PW'(in_z);
      p_zx <= PW'(qz) * PW'(in_x);
      p_wz <= PW'(qw) * PW'(in_z);
      p_xy <= PW'(qx) * PW'(in_y);
      p_yx <= PW'(qy) * PW'(in_x);
      p_xx <= PW'(qx) * PW'(in_x);
      p_yy <= PW'(qy) * PW'(in_y);
      p_zz <= PW'(qz) * PW'(in_z);
    end
  end

  // stage 2: t = q * v
  always_ff @(posedge clk) begin
    if (en2) begin
      tx <= TW'(p_wx) + TW'(p_yz) - TW'(p_zy);
      ty <= TW'(p_wy) - TW'(p_xz) + TW'(p_zx);
      tz <= TW'(p_wz) + TW'(p_xy) - TW'(p_yx);
      tw <= -TW'(p_xx) - TW'(p_yy) - TW'(p_zz);
    end
  end

  // stage 3: t * conj(q) products
  always_ff @(posedge clk) begin
    if (en3) begin
      m_wx <= RW'(tw) * RW'(qx);
      m_xw <= RW'(tx) * RW'(qw);
      m_yz <= RW'(ty) * RW'(qz);
      m_zy <= RW'(tz) * RW'(qy);
      m_wy <= RW'(tw) * RW'(qy);
      m_xz <= RW'(tx) * RW'(qz);
      m_yw <= RW'(ty) * RW'(qw);
      m_zx <= RW'(tz) * RW'(qx);
      m_wz <= RW'(tw) * RW'(qz);
      m_xy <= RW'(tx) * RW'(qy);
      m_yx <= RW'(ty) * RW'(qx);
      m_zw <= RW'(tz) * RW'(qw);
    end
  end

  // stage 4: sums with round half-up, shift down
  always_comb begin
    sum_x = -SW'(m_wx) + SW'(m_xw) - SW'(m_yz) + SW'(m_zy) + ROUND_BIAS;
    sum_y = -SW'(m_wy) + SW'(m_xz) + SW'(m_yw) - SW'(m_zx) + ROUND_BIAS;
    sum_z = -SW'(m_wz) - SW'(m_xy) + SW'(m_yx) + SW'(m_zw) + ROUND_BIAS;
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      rnd_x <= sum_x[SW-1:FRAC_SHIFT];
      rnd_y <= sum_y[SW-1:FRAC_SHIFT];
      rnd_z <= sum_z[SW-1:FRAC_SHIFT];
    end
  end

  // stage 5: saturate into the output register
  always_comb begin
    fit_x = (&rnd_x[RNW-1:VEC_WIDTH-1]) || !(|rnd_x[RNW-1:VEC_WIDTH-1]);
    fit_y = (&rnd_y[RNW-1:VEC_WIDTH-1]) || !(|rnd_y[RNW-1:VEC_WIDTH-1]);
    fit_z = (&rnd_z[RNW-1:VEC_WIDTH-1]) || !(|rnd_z[RNW-1:VEC_WIDTH-1]);
    out_x_next = fit_x ? rnd_x[VEC_WIDTH-1:0] : (rnd_x[RNW-1] ? VEC_MIN : VEC_MAX);
    out_y_next = fit_y ? rnd_y[VEC_WIDTH-1:0] : (rnd_y[RNW-1] ? VEC_MIN : VEC_MAX);
    out_z_next = fit_z ? rnd_z[VEC_WIDTH-1:0] : (rnd_z[RNW-1] ? VEC_MIN : VEC_MAX);
  end

  always_ff @(posedge clk) begin
    if (en_o) begin
      out_x     <= out_x_next;
      out_y     <= out_y_next;
      out_z     <= out_z_next;
      saturated <= !(fit_x && fit_y && fit_z);
    end
  end

  // checks
  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |->
      (out_x == VEC_MAX || out_x == VEC_MIN || out_y == VEC_MAX ||
       out_y == VEC_MIN || out_z == VEC_MAX || out_z == VEC_MIN))
    else $error("saturated set with no coordinate at a limit");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> v1 && v2 && v3 && v4 && out_valid)
    else $error("input stalled while a stage is empty");

  a_hold_blocked: assert property (@(posedge clk) disable iff (rst)
    v4 && !en_o |=> v4 && $stable(rnd_x) && $stable(rnd_y) && $stable(rnd_z))
    else $error("blocked stage lost its data");

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for quaternion_vector_rotate_top: streams vectors, predicts each
// rotated result in the bench and compares every output transaction field by field.
// Depends on qvr_pkg (register codes, quaternion width, rounding shift) and the block itself.
`timescale 1ns / 1ps

module tb_top;
  import qvr_pkg::*;

  localparam int VW             = 18;
  localparam int DRAIN_CYCLES   = 10;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PRESSURE_HOLD  = 250;
  localparam longint VEC_MAX    = (longint'(1) <<< (VW - 1)) - 1;
  localparam longint VEC_MIN    = -VEC_MAX - 1;

  typedef struct {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [VW-1:0] z;
  } vec3_t;

  typedef struct {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [VW-1:0] z;
    logic                 sat;
  } rotated_t;

  typedef enum int {QMIX_FULL, QMIX_UNIT_BALL, QMIX_EXTREME} quat_mix_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  cfg_reg_t              cfg_index = REG_QUAT_X;
  logic [QUAT_WIDTH-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  logic signed [VW-1:0]  in_x      = '0;
  logic signed [VW-1:0]  in_y      = '0;
  logic signed [VW-1:0]  in_z      = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic signed [VW-1:0]  out_x;
  logic signed [VW-1:0]  out_y;
  logic signed [VW-1:0]  out_z;
  logic                  saturated;

  // bench copy of the quaternion registers
  logic signed [QUAT_WIDTH-1:0] quat_x = '0;
  logic signed [QUAT_WIDTH-1:0] quat_y = '0;
  logic signed [QUAT_WIDTH-1:0] quat_z = '0;
  logic signed [QUAT_WIDTH-1:0] quat_w = QUAT_W_RESET;

  rotated_t rotated_q[$];

  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int hold_req       = 0;
  int hold_left      = 0;
  int idle_cycles    = 0;
  int fail_count     = 0;
  int vectors_sent   = 0;
  int results_seen   = 0;
  int saturated_seen = 0;
  int reg_writes     = 0;
  int quat_settings  = 0;

  quaternion_vector_rotate_top #(
    .VEC_WIDTH(VW)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_x     (in_x),
    .in_y     (in_y),
    .in_z     (in_z),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_x    (out_x),
    .out_y    (out_y),
    .out_z    (out_z),
    .saturated(saturated)
  );

  always #6 clk = ~clk;

  // q * v * conj(q), exact, then round half-up at the fraction shift and clamp
  function automatic rotated_t rotate_vector(vec3_t v);
    longint vx, vy, vz, qx, qy, qz, qw;
    longint tx, ty, tz, tw, rnd;
    longint acc [3];
    logic signed [VW-1:0] coord [3];
    rotated_t r;
    vx = longint'(v.x);
    vy = longint'(v.y);
    vz = longint'(v.z);
    qx = longint'(quat_x);
    qy = longint'(quat_y);
    qz = longint'(quat_z);
    qw = longint'(quat_w);
    tx = qw * vx + qy * vz - qz * vy;
    ty = qw * vy - qx * vz + qz * vx;
    tz = qw * vz + qx * vy - qy * vx;
    tw = -(qx * vx) - qy * vy - qz * vz;
    acc[0] = -(tw * qx) + tx * qw - ty * qz + tz * qy;
    acc[1] = -(tw * qy) + tx * qz + ty * qw - tz * qx;
    acc[2] = -(tw * qz) - tx * qy + ty * qx + tz * qw;
    r.sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      rnd = (acc[i] + (longint'(1) <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
      if (rnd > VEC_MAX) begin
        rnd   = VEC_MAX;
        r.sat = 1'b1;
      end else if (rnd < VEC_MIN) begin
        rnd   = VEC_MIN;
        r.sat = 1'b1;
      end
      coord[i] = rnd[VW-1:0];
    end
    r.x = coord[0];
    r.y = coord[1];
    r.z = coord[2];
    return r;
  endfunction

  function automatic vec3_t make_vec(longint x, longint y, longint z);
    vec3_t v;
    v.x = x[VW-1:0];
    v.y = y[VW-1:0];
    v.z = z[VW-1:0];
    return v;
  endfunction

  function automatic logic signed [VW-1:0] random_coord();
    logic [31:0] raw;
    raw = $urandom();
    case ($urandom_range(0, 15))
      0:       return VEC_MAX[VW-1:0];
      1:       return VEC_MIN[VW-1:0];
      2:       return '0;
      3:       return '1;
      default: return raw[VW-1:0];
    endcase
  endfunction

  function automatic logic [QUAT_WIDTH-1:0] random_quat_comp(quat_mix_t mix);
    logic [31:0] raw;
    int          span;
    raw = $urandom();
    case (mix)
      QMIX_FULL: return raw[QUAT_WIDTH-1:0];
      QMIX_UNIT_BALL: begin
        span = $urandom_range(0, 16384);
        span = span - 8192;
        return span[QUAT_WIDTH-1:0];
      end
      default: begin
        case (raw[1:0])
          2'd0:    return 16'h8000;
          2'd1:    return 16'h7fff;
          2'd2:    return 16'h0000;
          default: return QUAT_W_RESET;
        endcase
      end
    endcase
  endfunction

  function automatic void check_field(string name, logic signed [VW-1:0] expv,
                                      logic signed [VW-1:0] got);
    if (got !== expv) begin
      $error("%s mismatch: expected %0d, got %0d", name, expv, got);
      fail_count++;
    end
  endfunction

  // receiver: random stall, or a long hold when one is requested
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    rotated_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (rotated_q.size() == 0) begin
        $error("result with no vector pending: x=%0d y=%0d z=%0d sat=%0b",
               out_x, out_y, out_z, saturated);
        fail_count++;
      end else begin
        exp_r = rotated_q.pop_front();
        if (exp_r.sat) saturated_seen++;
        check_field("out_x", exp_r.x, out_x);
        check_field("out_y", exp_r.y, out_y);
        check_field("out_z", exp_r.z, out_z);
        check_field("saturated", VW'(exp_r.sat), VW'(saturated));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_vector(vec3_t v);
    logic stalled;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_x     <= v.x;
    in_y     <= v.y;
    in_z     <= v.z;
    forever begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
      if (!stalled) break;
    end
    rotated_q.push_back(rotate_vector(v));
    vectors_sent++;
  endtask

  // hold until every result is back, then let the stages empty
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (rotated_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_quat_reg(cfg_reg_t idx, logic [QUAT_WIDTH-1:0] value);
    logic ready;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    forever begin
      @(negedge clk);
      ready = cfg_ready;
      @(posedge clk);
      if (ready) break;
    end
    case (idx)
      REG_QUAT_X: quat_x = value;
      REG_QUAT_Y: quat_y = value;
      REG_QUAT_Z: quat_z = value;
      REG_QUAT_W: quat_w = value;
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic load_quaternion(logic [QUAT_WIDTH-1:0] qx, logic [QUAT_WIDTH-1:0] qy,
                                 logic [QUAT_WIDTH-1:0] qz, logic [QUAT_WIDTH-1:0] qw);
    drain_pipeline();
    write_quat_reg(REG_QUAT_W, qw);
    write_quat_reg(REG_QUAT_X, qx);
    write_quat_reg(REG_QUAT_Z, qz);
    write_quat_reg(REG_QUAT_Y, qy);
    cfg_valid <= 1'b0;
    quat_settings++;
  endtask

  task automatic test_identity_after_reset();
    send_vector(make_vec(VEC_MAX, VEC_MAX, VEC_MAX));
    send_vector(make_vec(VEC_MIN, VEC_MIN, VEC_MIN));
    send_vector(make_vec(0, 0, 0));
    send_vector(make_vec(VEC_MAX, VEC_MIN, -1));
    send_vector(make_vec(1, -1, 0));
    send_vector(make_vec(-12345, 54321, 77));
  endtask

  // w = 0.5 gives |q|^2 = 2^26, so inputs of the form 4k+2 land on exact halves
  task automatic test_round_half_up();
    load_quaternion(16'h0000, 16'h0000, 16'h0000, 16'sd8192);
    send_vector(make_vec(2, -2, 6));
    send_vector(make_vec(-6, 1, -1));
    send_vector(make_vec(3, -3, 0));
    send_vector(make_vec(-131070, 131070, -10));
  endtask

  task automatic test_saturation();
    load_quaternion(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_vector(make_vec(VEC_MAX, VEC_MAX, VEC_MAX));
    send_vector(make_vec(1000, -1000, 0));
    send_vector(make_vec(VEC_MIN, 0, VEC_MAX));
    load_quaternion(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_vector(make_vec(VEC_MIN, VEC_MIN, VEC_MIN));
    send_vector(make_vec(7, -7, 7));
    send_vector(make_vec(0, VEC_MAX, VEC_MIN));
  endtask

  task automatic test_axis_rotations();
    load_quaternion(16'sd16384, 16'h0000, 16'h0000, 16'h0000);
    send_vector(make_vec(100, -200, 300));
    send_vector(make_vec(VEC_MIN, VEC_MIN, VEC_MAX));
    load_quaternion(16'h0000, 16'h0000, 16'sd11585, 16'sd11585);
    send_vector(make_vec(VEC_MAX, 0, 0));
    send_vector(make_vec(0, VEC_MIN, 5));
  endtask

  task automatic test_random_stream(int send_pct, int recv_pct);
    quat_mix_t mix;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int blk = 0; blk < 4; blk++) begin
      case (blk)
        0:       mix = QMIX_FULL;
        2:       mix = QMIX_EXTREME;
        default: mix = QMIX_UNIT_BALL;
      endcase
      load_quaternion(random_quat_comp(mix), random_quat_comp(mix),
                      random_quat_comp(mix), random_quat_comp(mix));
      for (int n = 0; n < 133; n++)
        send_vector(make_vec(random_coord(), random_coord(), random_coord()));
    end
  endtask

  // receiver holds off while the sender keeps offering: stages fill and in_stall rises
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_quaternion(random_quat_comp(QMIX_UNIT_BALL), random_quat_comp(QMIX_UNIT_BALL),
                    random_quat_comp(QMIX_UNIT_BALL), random_quat_comp(QMIX_UNIT_BALL));
    hold_req = PRESSURE_HOLD;
    for (int n = 0; n < 40; n++)
      send_vector(make_vec(random_coord(), random_coord(), random_coord()));
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 6;
    recv_idle_pct = 79;
    test_identity_after_reset();
    test_round_half_up();
    test_saturation();
    test_axis_rotations();
    test_random_stream(6, 79);
    test_random_stream(79, 6);
    test_random_stream(0, 0);
    test_output_backpressure();
    drain_pipeline();
    $display("Rotated %0d vectors under %0d quaternion settings (%0d register writes),",
             vectors_sent, quat_settings, reg_writes);
    $display("checked %0d results, %0d of them clamped, with idle, stall and hold phases.",
             results_seen, saturated_seen);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
